[sv/tesp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesp_pkg
// Shared constants and types for the tree entry stream parser.
// ----------------------------------------------------------------------------
package tesp_pkg;

    localparam int unsigned DefHashBytes = 20;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned KindW   = 3;
    localparam int unsigned HidxW   = 5;
    localparam int unsigned StatusW = 2;
    localparam int unsigned ModeCntW = 3;

    localparam logic [KindW-1:0] KIND_MODE  = 3'd0;
    localparam logic [KindW-1:0] KIND_SPACE = 3'd1;
    localparam logic [KindW-1:0] KIND_NAME  = 3'd2;
    localparam logic [KindW-1:0] KIND_NUL   = 3'd3;
    localparam logic [KindW-1:0] KIND_HASH  = 3'd4;

    localparam logic [StatusW-1:0] ST_OK       = 2'd0;
    localparam logic [StatusW-1:0] ST_END_MODE = 2'd1;
    localparam logic [StatusW-1:0] ST_END_NAME = 2'd2;
    localparam logic [StatusW-1:0] ST_SHORT    = 2'd3;

    localparam logic [ByteW-1:0] CHAR_SPACE = 8'h20;
    localparam logic [ByteW-1:0] CHAR_NUL   = 8'h00;

    localparam logic [ModeCntW-1:0] TREE_MODE_LEN  = 3'd5;
    localparam logic [ModeCntW-1:0] MODE_COUNT_SAT = 3'd6;

    // Width of the packed result word on the output stream, padded to bytes.
    localparam int unsigned ResBits  = ByteW + HidxW + 1 + 1 + StatusW;
    localparam int unsigned TdataOutW = ((ResBits + 7) / 8) * 8;

    typedef struct packed {
        logic [KindW-1:0]   field_kind;
        logic [ByteW-1:0]   byte_value;
        logic [HidxW-1:0]   hash_index;
        logic               entry_done;
        logic               entry_is_tree;
        logic [StatusW-1:0] parse_status;
    } tesp_result_t;

    // Expected character of the tree mode "40000" at a given position.
    function automatic logic [ByteW-1:0] tree_mode_char(input logic [ModeCntW-1:0] pos);
        logic [ByteW-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h34;
            3'd1:    ch = 8'h30;
            3'd2:    ch = 8'h30;
            3'd3:    ch = 8'h30;
            3'd4:    ch = 8'h30;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[sv/tree_entry_stream_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_entry_stream_parser_top
// Byte-serial parser that tags each byte of a tree object body.
// ----------------------------------------------------------------------------
// The body enters one byte per transfer on the s_ stream; s_tlast marks the
// final byte of a body. Every accepted byte yields exactly one result
// transfer on the m_ stream, carrying the role of the byte (m_tuser), the
// byte itself, its index within the hash, an entry-complete flag, a tree
// flag and the end-of-body status (m_tdata).
// A byte that is accepted is registered in the result register and offered
// on m_ in the following cycle. Throughput is one byte per cycle while the
// receiver keeps m_tready high.
// The result register lets a new byte be accepted in the same cycle in which
// the waiting result is taken. While the receiver holds m_tready low with a
// result pending, s_tready drops and the result stays stable.
// Synchronous reset clears the output valid flag and returns the parser to
// the start of an entry. A byte with s_tlast also returns it there, so the
// next body may follow directly.
// ----------------------------------------------------------------------------
module tree_entry_stream_parser_top
    import tesp_pkg::*;
#(
    parameter int unsigned HASH_BYTES = DefHashBytes
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ByteW-1:0]     s_tdata,   // [7:0] content_byte
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] byte_value, [12:8] hash_index, [13] entry_done,
    // [14] entry_is_tree, [16:15] parse_status, upper bits zero
    output logic [TdataOutW-1:0] m_tdata,
    output logic [KindW-1:0]     m_tuser    // [2:0] field_kind
);

    logic         in_fire;
    tesp_result_t cls_res;
    tesp_result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    tesp_classifier #(
        .HASH_BYTES(HASH_BYTES)
    ) u_classifier (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .res     (cls_res)
    );

    tesp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (cls_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.field_kind;
    assign m_tdata = TdataOutW'({out_res.parse_status, out_res.entry_is_tree,
                                 out_res.entry_done, out_res.hash_index,
                                 out_res.byte_value});

endmodule

[sv/tesp_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesp_classifier
// Tags each byte with its role in the entry and keeps the parse state.
// ----------------------------------------------------------------------------
module tesp_classifier
    import tesp_pkg::*;
#(
    parameter int unsigned HASH_BYTES = DefHashBytes
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [ByteW-1:0] in_byte,
    input  logic             in_last,
    output tesp_result_t     res
);

    localparam int unsigned CntW = $clog2(HASH_BYTES + 1);
    localparam logic [CntW:0] HashEnd = (CntW + 1)'(HASH_BYTES);

    typedef enum logic [1:0] {
        PH_MODE = 2'd0,
        PH_NAME = 2'd1,
        PH_HASH = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                match_reg, match_next;
    logic [ModeCntW-1:0] mode_cnt_reg, mode_cnt_next;
    logic [CntW-1:0]     hash_cnt_reg, hash_cnt_next;
    logic [CntW:0]       hash_cnt_inc;
    logic                tree_flag;

    assign hash_cnt_inc = {1'b0, hash_cnt_reg} + 1'b1;
    assign tree_flag    = match_reg && (mode_cnt_reg == TREE_MODE_LEN);

    always_comb begin
        phase_next    = phase_reg;
        match_next    = match_reg;
        mode_cnt_next = mode_cnt_reg;
        hash_cnt_next = hash_cnt_reg;
        res.field_kind    = KIND_MODE;
        res.byte_value    = in_byte;
        res.hash_index    = '0;
        res.entry_done    = 1'b0;
        res.entry_is_tree = 1'b0;
        res.parse_status  = ST_OK;
        case (phase_reg)
            PH_NAME: begin
                if (in_byte == CHAR_NUL) begin
                    res.field_kind = KIND_NUL;
                    phase_next     = PH_HASH;
                    hash_cnt_next  = '0;
                    if (in_last) begin
                        res.entry_done    = 1'b1;
                        res.entry_is_tree = tree_flag;
                        res.parse_status  = ST_SHORT;
                    end
                end else begin
                    res.field_kind = KIND_NAME;
                    if (in_last) begin
                        res.parse_status = ST_END_NAME;
                    end
                end
            end
            PH_HASH: begin
                res.field_kind = KIND_HASH;
                res.hash_index = HidxW'(hash_cnt_reg);
                hash_cnt_next  = hash_cnt_inc[CntW-1:0];
                if (hash_cnt_inc >= HashEnd) begin
                    res.entry_done    = 1'b1;
                    res.entry_is_tree = tree_flag;
                    phase_next        = PH_MODE;
                    match_next        = 1'b1;
                    mode_cnt_next     = '0;
                    hash_cnt_next     = '0;
                end else if (in_last) begin
                    res.entry_done    = 1'b1;
                    res.entry_is_tree = tree_flag;
                    res.parse_status  = ST_SHORT;
                end
            end
            default: begin
                if (in_byte == CHAR_SPACE) begin
                    res.field_kind = KIND_SPACE;
                    phase_next     = PH_NAME;
                    if (in_last) begin
                        res.parse_status = ST_END_NAME;
                    end
                end else begin
                    res.field_kind = KIND_MODE;
                    if (mode_cnt_reg >= TREE_MODE_LEN ||
                        in_byte != tree_mode_char(mode_cnt_reg)) begin
                        match_next = 1'b0;
                    end
                    if (mode_cnt_reg < MODE_COUNT_SAT) begin
                        mode_cnt_next = mode_cnt_reg + 1'b1;
                    end
                    if (in_last) begin
                        res.parse_status = ST_END_MODE;
                    end
                end
            end
        endcase
        if (in_last) begin
            phase_next    = PH_MODE;
            match_next    = 1'b1;
            mode_cnt_next = '0;
            hash_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_MODE;
            match_reg    <= 1'b1;
            mode_cnt_reg <= '0;
            hash_cnt_reg <= '0;
        end else if (in_fire) begin
            phase_reg    <= phase_next;
            match_reg    <= match_next;
            mode_cnt_reg <= mode_cnt_next;
            hash_cnt_reg <= hash_cnt_next;
        end
    end

`ifndef SYNTH
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_last |=> phase_reg == PH_MODE && match_reg && mode_cnt_reg == '0
                               && hash_cnt_reg == '0)
        else $error("State not restarted after the final byte of a body.");

    a_tree_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res.entry_is_tree |-> res.entry_done)
        else $error("Tree flag raised without a completed entry.");

    a_hash_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, hash_cnt_reg} < HashEnd)
        else $error("Hash byte count reached the hash length.");

    a_mode_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_cnt_reg <= MODE_COUNT_SAT)
        else $error("Mode character count passed its saturation value.");
`endif

endmodule

[sv/tesp_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesp_out_stage
// Result register between the classifier and the output stream.
// ----------------------------------------------------------------------------
module tesp_out_stage
    import tesp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  tesp_result_t in_res,
    output logic         out_valid,
    input  logic         out_ready,
    output tesp_result_t out_res
);

    logic         valid_reg;
    tesp_result_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

[tb/tree_entry_stream_parser_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_entry_stream_parser_checker
// Scoreboard for the tree entry stream parser.
// ----------------------------------------------------------------------------
// Watches both streams at the rising clock edge. Every accepted input byte is
// run through an independent tag predictor, and the tag it yields is queued.
// Every result transfer is compared field by field against the oldest queued
// tag. Mismatch and progress counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module tree_entry_stream_parser_checker
    import tesp_pkg::*;
#(
    parameter int unsigned HASH_BYTES = DefHashBytes
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [ByteW-1:0]     s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [TdataOutW-1:0] m_tdata,
    input  logic [KindW-1:0]     m_tuser,
    output int                   fail_count,
    output int                   pending_count,
    output int                   entry_count,
    output int                   tree_count,
    output int                   early_end_count
);

    localparam int unsigned HidxLo   = ByteW;
    localparam int unsigned DoneBit  = ByteW + HidxW;
    localparam int unsigned TreeBit  = DoneBit + 1;
    localparam int unsigned StatusLo = TreeBit + 1;
    localparam int unsigned PadLo    = StatusLo + StatusW;
    localparam int          PrintCap = 200;

    localparam logic [ByteW-1:0] TREE_LEAD = 8'h34;
    localparam logic [ByteW-1:0] TREE_FILL = 8'h30;

    typedef enum logic [1:0] {
        PH_MODE = 2'd0,
        PH_NAME = 2'd1,
        PH_HASH = 2'd2
    } parse_phase_t;

    parse_phase_t      phase;
    logic              tree_prefix;
    logic [ModeCntW-1:0] mode_cnt;
    int unsigned       hash_cnt;

    tesp_result_t predicted_tags[$];
    tesp_result_t want;
    tesp_result_t tag;

    int mismatches;
    int results_seen;
    int entries;
    int trees;
    int early_ends;

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        if (mismatches < PrintCap) begin
            $display("result %0d: %s expected 0x%0h, got 0x%0h",
                     results_seen, what, exp_val, got_val);
        end
        mismatches++;
    endtask

    task automatic restart_entry();
        phase       = PH_MODE;
        tree_prefix = 1'b1;
        mode_cnt    = '0;
        hash_cnt    = 0;
    endtask

    function automatic logic entry_tree();
        return tree_prefix && (mode_cnt == TREE_MODE_LEN);
    endfunction

    task automatic tag_byte(input logic [ByteW-1:0] b, input logic last,
                            output tesp_result_t r);
        logic [ByteW-1:0] tree_ch;
        r = '0;
        r.byte_value   = b;
        r.parse_status = ST_OK;
        case (phase)
            PH_NAME: begin
                if (b == CHAR_NUL) begin
                    r.field_kind = KIND_NUL;
                    phase        = PH_HASH;
                    hash_cnt     = 0;
                    if (last) begin
                        r.entry_done    = 1'b1;
                        r.entry_is_tree = entry_tree();
                        r.parse_status  = ST_SHORT;
                    end
                end else begin
                    r.field_kind = KIND_NAME;
                    if (last) r.parse_status = ST_END_NAME;
                end
            end
            PH_HASH: begin
                r.field_kind = KIND_HASH;
                r.hash_index = hash_cnt[HidxW-1:0];
                hash_cnt++;
                if (hash_cnt >= HASH_BYTES) begin
                    r.entry_done    = 1'b1;
                    r.entry_is_tree = entry_tree();
                    restart_entry();
                end else if (last) begin
                    r.entry_done    = 1'b1;
                    r.entry_is_tree = entry_tree();
                    r.parse_status  = ST_SHORT;
                end
            end
            default: begin
                if (b == CHAR_SPACE) begin
                    r.field_kind = KIND_SPACE;
                    phase        = PH_NAME;
                    if (last) r.parse_status = ST_END_NAME;
                end else begin
                    r.field_kind = KIND_MODE;
                    tree_ch = (mode_cnt == '0) ? TREE_LEAD : TREE_FILL;
                    if (mode_cnt >= TREE_MODE_LEN || b != tree_ch) tree_prefix = 1'b0;
                    if (mode_cnt < MODE_COUNT_SAT) mode_cnt++;
                    if (last) r.parse_status = ST_END_MODE;
                end
            end
        endcase
        if (last) restart_entry();
    endtask

    initial begin
        mismatches      = 0;
        results_seen    = 0;
        entries         = 0;
        trees           = 0;
        early_ends      = 0;
        fail_count      = 0;
        pending_count   = 0;
        entry_count     = 0;
        tree_count      = 0;
        early_end_count = 0;
        restart_entry();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_entry();
            predicted_tags.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_tags.size() == 0) begin
                    report_mismatch("result with no byte pending", 0, 32'(m_tdata));
                end else begin
                    want = predicted_tags.pop_front();
                    if (m_tuser !== want.field_kind)
                        report_mismatch("field_kind", 32'(want.field_kind),
                                        32'(m_tuser));
                    if (m_tdata[ByteW-1:0] !== want.byte_value)
                        report_mismatch("byte_value", 32'(want.byte_value),
                                        32'(m_tdata[ByteW-1:0]));
                    if (m_tdata[HidxLo +: HidxW] !== want.hash_index)
                        report_mismatch("hash_index", 32'(want.hash_index),
                                        32'(m_tdata[HidxLo +: HidxW]));
                    if (m_tdata[DoneBit] !== want.entry_done)
                        report_mismatch("entry_done", 32'(want.entry_done),
                                        32'(m_tdata[DoneBit]));
                    if (m_tdata[TreeBit] !== want.entry_is_tree)
                        report_mismatch("entry_is_tree", 32'(want.entry_is_tree),
                                        32'(m_tdata[TreeBit]));
                    if (m_tdata[StatusLo +: StatusW] !== want.parse_status)
                        report_mismatch("parse_status", 32'(want.parse_status),
                                        32'(m_tdata[StatusLo +: StatusW]));
                    if (m_tdata[TdataOutW-1:PadLo] !== '0)
                        report_mismatch("padding", 0, 32'(m_tdata[TdataOutW-1:PadLo]));
                    if (want.entry_done) entries++;
                    if (want.entry_is_tree) trees++;
                    if (want.parse_status != ST_OK) early_ends++;
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                tag_byte(s_tdata, s_tlast, tag);
                predicted_tags.insert(predicted_tags.size(), tag);
            end
        end
        fail_count      <= mismatches;
        pending_count   <= predicted_tags.size();
        entry_count     <= entries;
        tree_count      <= trees;
        early_end_count <= early_ends;
    end

endmodule

[tb/tree_entry_stream_parser_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_entry_stream_parser_top_tb
// Stimulus and verdict for the tree entry stream parser.
// ----------------------------------------------------------------------------
// Drives tree object bodies into the parser: a few short bodies aimed at the
// corner cases first, then random bodies, most of them well-formed entry
// lists, some cut off at a random byte, some pure noise. Both streams see
// random gaps and stalls, with stretches where one side runs at full rate.
// The checker beside the parser does all prediction and comparison.
// ----------------------------------------------------------------------------
module tree_entry_stream_parser_top_tb;
    import tesp_pkg::*;

    localparam int unsigned HashBytes  = DefHashBytes;
    localparam int          ByteTarget = 1050;
    localparam int          CycleLimit = 400000;
    localparam int          DrainWait  = 8;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [ByteW-1:0]     s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TdataOutW-1:0] m_tdata;
    logic [KindW-1:0]     m_tuser;

    int fail_count;
    int pending_count;
    int entry_count;
    int tree_count;
    int early_end_count;

    int  cycle_count;
    int  bytes_sent;
    int  bodies_sent;
    bit  src_steady;
    bit  snk_steady;
    logic [ByteW-1:0] body_q[$];

    tree_entry_stream_parser_top #(
        .HASH_BYTES (HashBytes)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tree_entry_stream_parser_checker #(
        .HASH_BYTES (HashBytes)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .entry_count     (entry_count),
        .tree_count      (tree_count),
        .early_end_count (early_end_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!snk_steady && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    task automatic add_byte(input logic [ByteW-1:0] b);
        body_q.insert(body_q.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_hash(input int count);
        for (int i = 0; i < count; i++) add_byte(ByteW'($urandom_range(0, 255)));
    endtask

    task automatic add_random_entry();
        int sel;
        int len;
        logic [ByteW-1:0] ch;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            add_text("40000");
        end else if (sel < 6) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) add_byte(ByteW'(8'h30 + $urandom_range(0, 7)));
        end else if (sel == 6) begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++) begin
                ch = (i == 0) ? 8'h34 : 8'h30;
                if (i == len - 1 && $urandom_range(0, 2) == 0) ch = 8'h31;
                add_byte(ch);
            end
        end else if (sel == 8 || sel == 9) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                do ch = ByteW'($urandom_range(0, 255)); while (ch == CHAR_SPACE);
                add_byte(ch);
            end
        end
        add_byte(CHAR_SPACE);
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) add_byte(ByteW'($urandom_range(1, 255)));
        add_byte(CHAR_NUL);
        add_hash(HashBytes);
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_body();
        for (int i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
        body_q.delete();
        bodies_sent++;
        if ($urandom_range(0, 5) == 0) src_steady = !src_steady;
        if ($urandom_range(0, 5) == 0) snk_steady = !snk_steady;
    endtask

    initial begin
        int shape;
        int entries;
        int cut;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        bytes_sent  = 0;
        bodies_sent = 0;
        src_steady  = 1'b0;
        snk_steady  = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A body that ends inside the mode.
        add_text("7");
        send_body();
        // An empty mode that ends on its space.
        add_byte(CHAR_SPACE);
        send_body();
        // Extreme byte values as mode chars, ending inside the name.
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CHAR_SPACE);
        add_byte(8'hFF);
        send_body();
        // A tree entry cut off right at its NUL.
        add_text("40000 t");
        add_byte(CHAR_NUL);
        send_body();
        // A saturating long mode cut off two bytes into the hash.
        add_text("4000000 ");
        add_byte(CHAR_NUL);
        add_byte(8'h00);
        add_byte(8'hFF);
        send_body();

        while (bytes_sent < ByteTarget) begin
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                cut = $urandom_range(1, 12);
                for (int i = 0; i < cut; i++) add_byte(ByteW'($urandom_range(0, 255)));
            end else begin
                entries = $urandom_range(1, 3);
                for (int i = 0; i < entries; i++) add_random_entry();
                if (shape < 3) begin
                    cut = $urandom_range(1, body_q.size());
                    while (body_q.size() > cut) void'(body_q.pop_back());
                end
            end
            send_body();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);

        $display("Sent %0d bytes in %0d bodies; %0d entries completed, %0d of them trees.",
                 bytes_sent, bodies_sent, entry_count, tree_count);
        $display("Bodies ending early or on a short hash: %0d.", early_end_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches.", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
sv/tesp_pkg.sv
sv/tesp_classifier.sv
sv/tesp_out_stage.sv
sv/tree_entry_stream_parser_top.sv
tb/tree_entry_stream_parser_checker.sv
tb/tree_entry_stream_parser_top_tb.sv
